[rtl/pil_pkg.sv]
// ----------------------------------------------------------------------------
// pil_pkg
// Shared constants, codes and the controller/datapath interface types of the
// positional insert list.
// ----------------------------------------------------------------------------
package pil_pkg;

	// Store geometry
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths
	localparam int POS_W = 8;
	localparam int VAL_W = 32;

	// Result status codes
	typedef enum logic [1:0] {
		ST_ELEMENT = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Operations on the datapath index counter
	typedef enum logic [2:0] {
		IDX_HOLD = 3'd0,
		IDX_TOP  = 3'd1,
		IDX_CLR  = 3'd2,
		IDX_INC  = 3'd3,
		IDX_DEC  = 3'd4
	} idx_op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load;       // capture the input item
		idx_op_t idx_op;     // index counter operation
		logic    shift_rd;   // read entry at index, write it one place back next cycle
		logic    put;        // write the new value at its position, bump the count
		logic    emit_rd;    // read entry at index for the result queue
		logic    emit_dir;   // pass direction of that read
		logic    emit_last;  // final result of the item
		logic    err_push;   // queue a single error result
		status_t err_code;   // status of that error result
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pos_bad;     // negative position or beyond the count
		logic full;        // store holds CAPACITY entries
		logic no_shift;    // position equals the count (append)
		logic idx_at_pos;  // index has reached the insert position
		logic idx_zero;    // index is at the front
		logic idx_last;    // index is at the back
		logic space;       // result queue can take one more entry
	} sts_t;

endpackage

[rtl/pil_ram.sv]
// ----------------------------------------------------------------------------
// pil_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/pil_dp.sv]
// ----------------------------------------------------------------------------
// pil_dp
// Datapath: item capture, entry count, index counter, list store and a
// two-entry result queue in front of the output channel.
// ----------------------------------------------------------------------------
module pil_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pil_pkg::cmd_t                cmd,
	output pil_pkg::sts_t                sts,
	input  logic [pil_pkg::POS_W-1:0]    in_pos,
	input  logic [pil_pkg::VAL_W-1:0]    in_val,
	output logic                         out_valid,
	input  logic                         out_ready,
	output pil_pkg::status_t             out_status,
	output logic                         out_dir,
	output logic [pil_pkg::VAL_W-1:0]    out_value,
	output logic                         out_last
);
	import pil_pkg::*;

	typedef struct packed {
		status_t           status;
		logic              dir;
		logic [VAL_W-1:0]  value;
		logic              last;
	} entry_t;

	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             sh_pend_q;
	logic [IDX_W-1:0] sh_addr_q;
	logic             emit_pend_q;
	logic             tag_dir_q;
	logic             tag_last_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic [VAL_W-1:0] ram_rdata;

	entry_t           fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       occ_q;
	logic             push;
	logic             pop;
	entry_t           push_entry;
	entry_t           head;
	logic [2:0]       load_sum;

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= in_pos;
			val_q <= in_val;
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.put) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			case (cmd.idx_op)
				IDX_TOP: idx_q <= IDX_W'(count_q - CNT_W'(1));
				IDX_CLR: idx_q <= '0;
				IDX_INC: idx_q <= idx_q + IDX_W'(1);
				IDX_DEC: idx_q <= idx_q - IDX_W'(1);
				default: idx_q <= idx_q;
			endcase
		end
	end

	// Read tracking: shift write-back and result reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_pend_q   <= 1'b0;
			emit_pend_q <= 1'b0;
		end else begin
			sh_pend_q   <= cmd.shift_rd;
			emit_pend_q <= cmd.emit_rd;
		end
	end

	always_ff @(posedge clk) begin
		sh_addr_q  <= idx_q + IDX_W'(1);
		tag_dir_q  <= cmd.emit_dir;
		tag_last_q <= cmd.emit_last;
	end

	// List store
	assign ram_we    = sh_pend_q | cmd.put;
	assign ram_waddr = sh_pend_q ? sh_addr_q : pos_q[IDX_W-1:0];
	assign ram_wdata = sh_pend_q ? ram_rdata : val_q;

	pil_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.shift_rd | cmd.emit_rd),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Result queue
	assign push = emit_pend_q | cmd.err_push;
	assign pop  = out_valid & out_ready;

	always_comb begin
		if (cmd.err_push) begin
			push_entry = '{status: cmd.err_code, dir: 1'b0, value: '0, last: 1'b1};
		end else begin
			push_entry = '{status: ST_ELEMENT, dir: tag_dir_q, value: ram_rdata,
				last: tag_last_q};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			occ_q <= occ_q + 2'(push) - 2'(pop);
		end
	end

	assign head       = fifo_q[rd_ptr_q];
	assign out_valid  = (occ_q != 2'd0);
	assign out_status = head.status;
	assign out_dir    = head.dir;
	assign out_value  = head.value;
	assign out_last   = head.last;

	// Queue room counting the read in flight and this cycle's transfer
	assign load_sum = 3'(occ_q) + 3'(emit_pend_q) - 3'(pop);

	// Status to controller
	assign sts.pos_bad    = pos_q[POS_W-1] | (pos_q > POS_W'(count_q));
	assign sts.full       = (count_q == CNT_W'(CAPACITY));
	assign sts.no_shift   = (pos_q == POS_W'(count_q));
	assign sts.idx_at_pos = (POS_W'(idx_q) == pos_q);
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.idx_last   = (CNT_W'(idx_q) == count_q - CNT_W'(1));
	assign sts.space      = (load_sum <= 3'd1);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && occ_q == 2'd2 && !pop))
		else $error("result queue overflow");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(sh_pend_q && cmd.put))
		else $error("shift write-back and insert write collide");

	a_one_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit_pend_q && cmd.err_push))
		else $error("two results pushed in one cycle");
`endif

endmodule

[rtl/pil_ctrl.sv]
// ----------------------------------------------------------------------------
// pil_ctrl
// Controller: checks each item, sequences the shift, the insert write and
// the two result passes.
// ----------------------------------------------------------------------------
module pil_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output pil_pkg::cmd_t  cmd,
	input  pil_pkg::sts_t  sts
);
	import pil_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_SHIFT = 8'b0000_0100,
		S_DRAIN = 8'b0000_1000,
		S_PUT   = 8'b0001_0000,
		S_FWD   = 8'b0010_0000,
		S_BWD   = 8'b0100_0000,
		S_ERR   = 8'b1000_0000
	} state_t;

	state_t  state_q;
	state_t  state_d;
	status_t err_q;
	status_t err_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= ST_INVALID;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.pos_bad) begin
					err_d   = ST_INVALID;
					state_d = S_ERR;
				end else if (sts.full) begin
					err_d   = ST_FULL;
					state_d = S_ERR;
				end else if (sts.no_shift) begin
					state_d = S_PUT;
				end else begin
					cmd.idx_op = IDX_TOP;
					state_d    = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift_rd = 1'b1;
				if (sts.idx_at_pos) begin
					state_d = S_DRAIN;
				end else begin
					cmd.idx_op = IDX_DEC;
				end
			end
			S_DRAIN: begin
				state_d = S_PUT;
			end
			S_PUT: begin
				cmd.put    = 1'b1;
				cmd.idx_op = IDX_CLR;
				state_d    = S_FWD;
			end
			S_FWD: begin
				if (sts.space) begin
					cmd.emit_rd = 1'b1;
					if (sts.idx_last) begin
						state_d = S_BWD;
					end else begin
						cmd.idx_op = IDX_INC;
					end
				end
			end
			S_BWD: begin
				if (sts.space) begin
					cmd.emit_rd   = 1'b1;
					cmd.emit_dir  = 1'b1;
					cmd.emit_last = sts.idx_zero;
					if (sts.idx_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_op = IDX_DEC;
					end
				end
			end
			S_ERR: begin
				if (sts.space) begin
					cmd.err_push = 1'b1;
					cmd.err_code = err_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_no_emit_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift_rd || cmd.put) |-> !(cmd.emit_rd || cmd.err_push))
		else $error("result issued during the insert phase");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_rd && cmd.emit_last) |=> (state_q == S_IDLE))
		else $error("final result issued without returning to idle");

	a_put_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> (state_q == S_FWD))
		else $error("insert write not followed by the forward pass");
`endif

endmodule

[rtl/positional_insert_list_top.sv]
// ----------------------------------------------------------------------------
// positional_insert_list_top
// Ordered list of signed words with insert-at-position and full printout.
// ----------------------------------------------------------------------------
// Input stream: one transfer per insert request, position in tdata[7:0]
// (signed) and value in tdata[39:8]. Output stream: element value in tdata,
// status and pass direction in tuser, tlast on the final result of a request.
// A successful insert returns every stored word front to back, then back to
// front (2*count results). A negative position or one beyond the count gives
// a single invalid-position result; a valid position into a full store gives
// a single list-full result. Neither changes the list.
// Results leave at one per cycle while the receiver accepts them; the single
// read port of the list store sets both the shift and the printout pace. The
// input is taken once every result of the previous request has been read from
// the store.
// Reset clears the count, so the list starts empty; stored words need no
// clearing. When the receiver stalls, a two-entry result queue fills and the
// store reads pause until it drains; nothing is dropped.
// ----------------------------------------------------------------------------
module positional_insert_list_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [7:0] insert_position, [39:8] item_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] element_value
	output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] direction
	output logic        m_axis_tlast
);
	import pil_pkg::*;

	cmd_t    cmd;
	sts_t    sts;
	status_t out_status;
	logic    out_dir;

	pil_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pil_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_pos     (s_axis_tdata[POS_W-1:0]),
		.in_val     (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (out_status),
		.out_dir    (out_dir),
		.out_value  (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

	// Output sideband
	assign m_axis_tuser = {out_dir, out_status};

endmodule

[test/positional_insert_list_top_tb.sv]
// ----------------------------------------------------------------------------
// positional_insert_list_top_tb
// Self-checking bench for the positional insert list.
// ----------------------------------------------------------------------------
// A directed table comes first. It covers bad positions on an empty list, the
// first insert, and front, middle and append inserts with extreme words. A
// random stream follows. It is weighted towards positions that are in range,
// so that the store fills and the list-full refusal is reached, with bad
// positions mixed in throughout. A shadow list predicts every printout pass.
// Each output transfer is compared field by field, in order. Both stream
// sides idle in short random bursts, and the closing stretch runs flat out.
// ----------------------------------------------------------------------------
module positional_insert_list_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pil_pkg::*;

	localparam int N_ITEMS    = 370;
	localparam int N_DIRECTED = 14;
	localparam int N_QUIET    = 40;
	localparam int TAIL_CYC   = 120;

	// How a table row is checked
	typedef enum logic [1:0] {
		CHK_MODEL = 2'd0,   // shadow list decides
		CHK_ERROR = 2'd1,   // single error result of the given code
		CHK_SOLO  = 2'd2    // first insert into an empty list
	} chk_t;

	typedef struct packed {
		logic [7:0]  pos;
		logic [31:0] val;
		chk_t        chk;
		status_t     code;
	} stim_row_t;

	typedef struct packed {
		status_t     status;
		logic        dir;
		logic [31:0] value;
		logic        last;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // [7:0] insert_position, [39:8] item_value
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] element_value
	logic [2:0]  m_axis_tuser;   // [1:0] status, [2] direction
	logic        m_axis_tlast;

	// Check mode travelling alongside the driven item
	chk_t    drv_chk;
	status_t drv_code;

	// Shadow list
	logic [31:0] shadow_words [CAPACITY];
	int          shadow_len;

	list_result_t expected_results [$];

	bit quiet;
	int n_items, n_results, n_inserts, n_invalid, n_full, n_errors;

	stim_row_t directed_rows [N_DIRECTED];

	positional_insert_list_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic push_result(input status_t st, input logic dir, input logic [31:0] value,
			input logic last);
		list_result_t r;
		r.status = st;
		r.dir    = dir;
		r.value  = value;
		r.last   = last;
		expected_results.push_back(r);
	endtask

	// Apply one insert request to the shadow list; queue its printout if asked
	task automatic list_insert_predict(input logic [7:0] pos, input logic [31:0] val,
			input bit record);
		int i;
		if (pos[7] || int'(pos) > shadow_len) begin
			n_invalid++;
			if (record)
				push_result(ST_INVALID, 1'b0, 32'd0, 1'b1);
			return;
		end
		if (shadow_len >= CAPACITY) begin
			n_full++;
			if (record)
				push_result(ST_FULL, 1'b0, 32'd0, 1'b1);
			return;
		end
		for (i = shadow_len; i > int'(pos); i--)
			shadow_words[i] = shadow_words[i-1];
		shadow_words[pos[IDX_W-1:0]] = val;
		shadow_len++;
		n_inserts++;
		if (record) begin
			for (i = 0; i < shadow_len; i++)
				push_result(ST_ELEMENT, 1'b0, shadow_words[i], 1'b0);
			for (i = shadow_len; i > 0; i--)
				push_result(ST_ELEMENT, 1'b1, shadow_words[i-1], i == 1);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	// Input transfers feed the shadow list, output transfers are checked in order
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				n_items++;
				if (drv_chk == CHK_MODEL) begin
					list_insert_predict(s_axis_tdata[7:0], s_axis_tdata[39:8], 1'b1);
				end else begin
					list_insert_predict(s_axis_tdata[7:0], s_axis_tdata[39:8], 1'b0);
					if (drv_chk == CHK_ERROR) begin
						push_result(drv_code, 1'b0, 32'd0, 1'b1);
					end else begin
						push_result(ST_ELEMENT, 1'b0, s_axis_tdata[39:8], 1'b0);
						push_result(ST_ELEMENT, 1'b1, s_axis_tdata[39:8], 1'b1);
					end
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					n_errors++;
					$display("%0t ns: unexpected result, expected none actual %h user %h last %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(m_axis_tuser[1:0]));
					check_field("direction", 32'(want.dir), 32'(m_axis_tuser[2]));
					check_field("element_value", want.value, m_axis_tdata);
					check_field("last", 32'(want.last), 32'(m_axis_tlast));
				end
			end
		end
	end

	// Receiver: random stall bursts, none in the quiet stretch
	initial begin
		int hold;
		hold = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold != 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 4) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Present one item and hold it until the transfer
	task automatic send_item(input logic [7:0] pos, input logic [31:0] val, input chk_t chk,
			input status_t code);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {val, pos};
		drv_chk       <= chk;
		drv_code      <= code;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h7FFF_FFFF;
			3:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Stimulus
	initial begin
		int k, drv_count;
		logic [7:0]  pos;
		logic [31:0] val;

		directed_rows = '{
			'{8'd1,   32'd1234,       CHK_ERROR, ST_INVALID},  // beyond empty list
			'{8'hFF,  32'h1234_5678,  CHK_ERROR, ST_INVALID},  // -1
			'{8'h80,  32'hFFFF_FFFF,  CHK_ERROR, ST_INVALID},  // most negative
			'{8'h7F,  32'h8000_0000,  CHK_ERROR, ST_INVALID},  // largest positive
			'{8'd0,   32'h7FFF_FFFF,  CHK_SOLO,  ST_ELEMENT},  // first entry
			'{8'd0,   32'h8000_0000,  CHK_MODEL, ST_ELEMENT},  // front
			'{8'd2,   32'h0000_0000,  CHK_MODEL, ST_ELEMENT},  // append
			'{8'd1,   32'hFFFF_FFFF,  CHK_MODEL, ST_ELEMENT},  // middle
			'{8'd5,   32'h0000_0001,  CHK_ERROR, ST_INVALID},  // one past the count
			'{8'd4,   32'h5555_5555,  CHK_MODEL, ST_ELEMENT},  // append
			'{8'd2,   32'hAAAA_AAAA,  CHK_MODEL, ST_ELEMENT},  // middle
			'{8'h80,  32'h7FFF_FFFF,  CHK_ERROR, ST_INVALID},
			'{8'd0,   32'h0000_0001,  CHK_MODEL, ST_ELEMENT},  // front
			'{8'd6,   32'hDEAD_BEEF,  CHK_MODEL, ST_ELEMENT}   // just before the back
		};

		quiet = 1'b0;
		shadow_len = 0;
		n_items = 0; n_results = 0; n_inserts = 0; n_invalid = 0; n_full = 0; n_errors = 0;
		drv_count = 0;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		drv_chk       <= CHK_MODEL;
		drv_code      <= ST_ELEMENT;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_ITEMS; k++) begin
			if (k >= N_ITEMS - N_QUIET)
				quiet = 1'b1;
			if (!quiet && $urandom_range(0, 2) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			if (k < N_DIRECTED) begin
				pos = directed_rows[k].pos;
				send_item(pos, directed_rows[k].val, directed_rows[k].chk,
					directed_rows[k].code);
			end else begin
				// mostly positions in range, some just outside, some anywhere
				case ($urandom_range(0, 9))
					0, 1:    pos = 8'($urandom_range(0, 255));
					2:       pos = (drv_count + 1 < 128) ? 8'(drv_count + 1) : 8'hFF;
					3:       pos = 8'(drv_count);
					4:       pos = 8'd0;
					default: pos = 8'($urandom_range(0, drv_count));
				endcase
				val = pick_word();
				send_item(pos, val, CHK_MODEL, ST_ELEMENT);
			end
			if (!pos[7] && int'(pos) <= drv_count && drv_count < CAPACITY)
				drv_count++;
		end
		s_axis_tvalid <= 1'b0;

		// drain, then give the block time to show anything stray
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("Covered %0d requests: %0d inserts, %0d bad positions, %0d refused as full.",
			n_items, n_inserts, n_invalid, n_full);
		$display("Checked %0d result transfers, %0d mismatches.", n_results, n_errors);
		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("positional_insert_list_top verification clean");
		end else begin
			$display("positional_insert_list_top verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("Timeout with %0d results outstanding.", expected_results.size());
		$display("positional_insert_list_top verification failed");
		$finish;
	end

endmodule
